### src/scaled_column_drawer_top_defines.svh
// Assertion macros shared by the column drawer RTL.
`ifndef SCALED_COLUMN_DRAWER_TOP_DEFINES_SVH
`define SCALED_COLUMN_DRAWER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define SCD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scd assertion failed");
// next-cycle implication
`define SCD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scd assertion failed");
`else
`define SCD_ASSERT_NOW(lbl, ante, cons)
`define SCD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### src/scd_pkg.sv
// Types and constants of the scaled column drawer.
package scd_pkg;

  localparam int TexelDepth = 4096;  // power of two
  localparam int TexelAw    = $clog2(TexelDepth);
  localparam int ShadeDepth = 256;
  localparam int ShadeAw    = $clog2(ShadeDepth);
  localparam int MaxWidth   = 8;
  localparam int WidthW     = $clog2(MaxWidth + 1);
  localparam int FracBits   = 16;
  localparam int MaxLength  = 1023;
  localparam int LenW       = $clog2(MaxLength + 1);
  localparam int AddrW      = 20;
  localparam int PitchW     = 12;
  localparam logic [PitchW-1:0] PitchReset = PitchW'(320);
  localparam int QDepth     = 8;
  localparam int QAw        = $clog2(QDepth);
  localparam int QCntW      = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    CMD_LOAD_TEXEL = 2'd0,
    CMD_LOAD_SHADE = 2'd1,
    CMD_START      = 2'd2,
    CMD_ROW        = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_PLAIN    = 2'd0,
    MODE_LIT      = 2'd1,
    MODE_SHADE_BG = 2'd2,
    MODE_NONE     = 2'd3
  } mode_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [11:0] table_index;
    logic [7:0]  table_data;
    logic [31:0] frac_start;
    logic [31:0] step;
    logic [11:0] source_offset;
    logic [19:0] dest_start;
    logic [9:0]  column_length;
    logic [3:0]  column_width;
    logic [1:0]  draw_mode;
    logic [7:0]  background_pixel;
  } in_word_t;

  typedef struct packed {
    logic [19:0] dest_address;
    logic [7:0]  pixel_value;
    logic        last_of_run;
  } out_word_t;

  // one row's worth of writes, queued between front and back
  typedef struct packed {
    logic [AddrW-1:0]  dest;
    logic [7:0]        pix;
    logic [WidthW-1:0] width;
  } job_t;

endpackage

### src/scd_front.sv
// Front end: command decode, column state, texel and shade lookups.
`include "scaled_column_drawer_top_defines.svh"

module scd_front import scd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  in_word_t          in_word_i,
  output logic              in_stall_o,
  input  logic              cfg_we_i,
  input  logic [PitchW-1:0] cfg_wdata_i,
  input  logic [QCntW-1:0]  q_cnt_i,
  output logic              push_o,
  output job_t              push_job_o
);

  logic [7:0] texel_mem [TexelDepth];
  logic [7:0] shade_mem [ShadeDepth];

  // column state
  logic [31:0]        coord_q;
  logic [31:0]        step_q;
  logic [TexelAw-1:0] base_q;
  logic [AddrW-1:0]   dest_q;
  logic [LenW-1:0]    rows_q;
  logic [WidthW-1:0]  width_q;
  mode_e              mode_q;
  logic [PitchW-1:0]  pitch_q;

  // stage B: texel read data valid, shade lookup/write
  logic               b_push_q, b_swr_q;
  mode_e              b_mode_q;
  logic [AddrW-1:0]   b_dest_q;
  logic [WidthW-1:0]  b_width_q;
  logic [ShadeAw-1:0] b_sidx_q;
  logic [7:0]         b_sdata_q;
  logic [7:0]         texel_rdata_q;

  // stage C: pixel ready, push to queue
  logic               c_push_q;
  mode_e              c_mode_q;
  logic [AddrW-1:0]   c_dest_q;
  logic [WidthW-1:0]  c_width_q;
  logic [7:0]         c_texel_q;
  logic [7:0]         shade_rdata_q;

  logic               accept, row_go, row_emit;
  logic [QCntW:0]     credit_used;
  logic [TexelAw-1:0] texel_ra;
  logic [ShadeAw-1:0] shade_ra;
  logic [WidthW-1:0]  start_width;
  logic [LenW-1:0]    start_len;

  assign credit_used = (QCntW+1)'(q_cnt_i) + (QCntW+1)'(b_push_q) + (QCntW+1)'(c_push_q);
  assign in_stall_o  = credit_used >= (QCntW+1)'(QDepth);
  assign accept      = in_valid_i && !in_stall_o;
  assign row_go      = accept && (in_word_i.command == CMD_ROW) && (rows_q != '0);
  assign row_emit    = row_go && (mode_q != MODE_NONE);
  assign texel_ra    = TexelAw'(32'(base_q) + (coord_q >> FracBits));

  always_comb begin
    if (in_word_i.column_width == '0) begin
      start_width = WidthW'(1);
    end else if (32'(in_word_i.column_width) > MaxWidth) begin
      start_width = WidthW'(MaxWidth);
    end else begin
      start_width = WidthW'(in_word_i.column_width);
    end
    if (32'(in_word_i.column_length) > MaxLength) begin
      start_len = LenW'(MaxLength);
    end else begin
      start_len = LenW'(in_word_i.column_length);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_q <= PitchReset;
    end else if (cfg_we_i) begin
      pitch_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coord_q <= '0;
      step_q  <= '0;
      base_q  <= '0;
      dest_q  <= '0;
      rows_q  <= '0;
      width_q <= WidthW'(1);
      mode_q  <= MODE_PLAIN;
    end else if (accept && in_word_i.command == CMD_START) begin
      coord_q <= in_word_i.frac_start;
      step_q  <= in_word_i.step;
      base_q  <= TexelAw'(in_word_i.source_offset);
      dest_q  <= in_word_i.dest_start;
      rows_q  <= start_len;
      width_q <= start_width;
      mode_q  <= mode_e'(in_word_i.draw_mode);
    end else if (row_go) begin
      coord_q <= coord_q + step_q;
      dest_q  <= dest_q + AddrW'(pitch_q);
      rows_q  <= rows_q - LenW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_word_i.command == CMD_LOAD_TEXEL) begin
      texel_mem[TexelAw'(in_word_i.table_index)] <= in_word_i.table_data;
    end
    texel_rdata_q <= texel_mem[texel_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_push_q <= 1'b0;
      b_swr_q  <= 1'b0;
      c_push_q <= 1'b0;
    end else begin
      b_push_q <= row_emit;
      b_swr_q  <= accept && (in_word_i.command == CMD_LOAD_SHADE);
      c_push_q <= b_push_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_mode_q  <= mode_q;
    b_dest_q  <= dest_q;
    b_width_q <= (mode_q == MODE_SHADE_BG) ? WidthW'(1) : width_q;
    b_sidx_q  <= (in_word_i.command == CMD_LOAD_SHADE) ?
                 ShadeAw'(in_word_i.table_index) : ShadeAw'(in_word_i.background_pixel);
    b_sdata_q <= in_word_i.table_data;
    c_mode_q  <= b_mode_q;
    c_dest_q  <= b_dest_q;
    c_width_q <= b_width_q;
    c_texel_q <= texel_rdata_q;
  end

  // lit rows look up the texel, shade-existing rows the background byte
  assign shade_ra = (b_mode_q == MODE_LIT) ? ShadeAw'(texel_rdata_q) : b_sidx_q;

  always_ff @(posedge clk_i) begin
    if (b_swr_q) begin
      shade_mem[b_sidx_q] <= b_sdata_q;
    end
    shade_rdata_q <= shade_mem[shade_ra];
  end

  assign push_o           = c_push_q;
  assign push_job_o.dest  = c_dest_q;
  assign push_job_o.width = c_width_q;
  assign push_job_o.pix   = (c_mode_q == MODE_PLAIN) ? c_texel_q : shade_rdata_q;

  `SCD_ASSERT_NOW(a_credit_bound, 1'b1, credit_used <= (QCntW+1)'(QDepth))
  `SCD_ASSERT_NEXT(a_b_to_c, b_push_q, c_push_q)
  `SCD_ASSERT_NEXT(a_row_count, row_go, rows_q == $past(rows_q) - LenW'(1))

endmodule

### src/scd_queue.sv
// Row job queue between front and back.
module scd_queue import scd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  job_t             push_job_i,
  input  logic             pop_i,
  output job_t             head_o,
  output logic             empty_o,
  output logic [QCntW-1:0] cnt_o
);

  job_t             mem_q [QDepth];
  logic [QAw-1:0]   wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (32'(wr_q) == QDepth - 1) ? '0 : wr_q + QAw'(1);
      end
      if (pop_i) begin
        rd_q <= (32'(rd_q) == QDepth - 1) ? '0 : rd_q + QAw'(1);
      end
      cnt_q <= cnt_q + QCntW'(push_i) - QCntW'(pop_i);
    end
  end

  assign head_o  = mem_q[rd_q];
  assign empty_o = (cnt_q == '0);
  assign cnt_o   = cnt_q;

endmodule

### src/scd_back.sv
// Back end: replicates each queued row into pixel writes.
`include "scaled_column_drawer_top_defines.svh"

module scd_back import scd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  job_t      head_i,
  input  logic      empty_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  logic [WidthW-1:0] idx_q;
  logic              out_valid_q;
  out_word_t         out_word_q;
  logic              load, take, last;

  assign load  = !out_valid_q || !out_stall_i;
  assign take  = load && !empty_i;
  assign last  = ((WidthW+1)'(idx_q) + (WidthW+1)'(1)) == (WidthW+1)'(head_i.width);
  assign pop_o = take && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= !empty_i;
      end
      if (take) begin
        idx_q <= last ? '0 : idx_q + WidthW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_word_q.dest_address <= head_i.dest + AddrW'(idx_q);
      out_word_q.pixel_value  <= head_i.pix;
      out_word_q.last_of_run  <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  `SCD_ASSERT_NOW(a_pop_nonempty, pop_o, !empty_i)
  `SCD_ASSERT_NOW(a_idx_in_row, !empty_i, idx_q < head_i.width)
  `SCD_ASSERT_NOW(a_mid_row_head, idx_q != '0, !empty_i)

endmodule

### src/scaled_column_drawer_top.sv
// Top level of the scaled column drawer.
//
//  channel | signals                          | word
//  in      | in_valid_i, in_stall_o           | in_word_t (command and column fields)
//  out     | out_valid_o, out_stall_i         | out_word_t (address, pixel, last)
//  config  | cfg_we_i, cfg_wdata_i            | row pitch, 12 bits
//
// One input word per cycle unless in_stall_o; a row word yields width writes (one in
// shade-existing mode, none in MODE_NONE or past the column end), one write per cycle
// unless out_stall_i, so the output replicator sets the row rate.
// Input stalls once 8 rows sit in the row queue and the two lookup stages together.
// Reset clears the column state and sets the pitch to 320; stores are not cleared.
module scaled_column_drawer_top import scd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_word_t          in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_word_t         out_word_o,
  input  logic              cfg_we_i,
  input  logic [PitchW-1:0] cfg_wdata_i
);

  logic             push, pop, empty;
  job_t             push_job, head;
  logic [QCntW-1:0] q_cnt;

  scd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_word_i   (in_word_i),
    .in_stall_o  (in_stall_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_cnt_i     (q_cnt),
    .push_o      (push),
    .push_job_o  (push_job)
  );

  scd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (empty),
    .cnt_o      (q_cnt)
  );

  scd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

### tb/sv/scaled_column_drawer_top_tb.sv
// Self-checking testbench for the scaled column drawer top level.
module scaled_column_drawer_top_tb import scd_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ClkPeriod   = 8;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 32;
  localparam int IdleLimit   = 4000;
  localparam int PhaseItems  = 120;

  // Tracks column state and the byte writes each row word must produce.
  class column_model;
    logic [7:0]         texel_mem   [TexelDepth];
    bit                 texel_known [TexelDepth];
    logic [7:0]         shade_mem   [ShadeDepth];
    bit                 shade_known [ShadeDepth];
    logic [31:0]        tex_coord;
    logic [31:0]        coord_step;
    logic [AddrW-1:0]   row_dest;
    logic [LenW-1:0]    rows_left;
    logic [TexelAw-1:0] texel_base;
    logic [WidthW-1:0]  rep_width;
    mode_e              mode;
    logic [PitchW-1:0]  row_pitch;
    out_word_t          due_writes [$];
    int                 mismatches;

    function new();
      tex_coord  = '0;
      coord_step = '0;
      row_dest   = '0;
      rows_left  = '0;
      texel_base = '0;
      rep_width  = WidthW'(1);
      mode       = MODE_PLAIN;
      row_pitch  = PitchReset;
      mismatches = 0;
    endfunction

    function logic [TexelAw-1:0] texel_slot();
      return texel_base + tex_coord[FracBits +: TexelAw];
    endfunction

    function void take_word(in_word_t w);
      logic [LenW-1:0] len;
      logic [3:0]      wid;
      logic [7:0]      pix;
      case (cmd_e'(w.command))
        CMD_LOAD_TEXEL: begin
          texel_mem[w.table_index[TexelAw-1:0]]   = w.table_data;
          texel_known[w.table_index[TexelAw-1:0]] = 1'b1;
        end
        CMD_LOAD_SHADE: begin
          shade_mem[w.table_index[ShadeAw-1:0]]   = w.table_data;
          shade_known[w.table_index[ShadeAw-1:0]] = 1'b1;
        end
        CMD_START: begin
          len = w.column_length;
          if (len > MaxLength) len = LenW'(MaxLength);
          wid = w.column_width;
          if (wid == 0) wid = 4'd1;
          else if (wid > MaxWidth) wid = 4'(MaxWidth);
          tex_coord  = w.frac_start;
          coord_step = w.step;
          texel_base = w.source_offset[TexelAw-1:0];
          row_dest   = w.dest_start;
          rows_left  = len;
          rep_width  = WidthW'(wid);
          mode       = mode_e'(w.draw_mode);
        end
        CMD_ROW: begin
          if (rows_left != 0) begin
            if (mode == MODE_PLAIN || mode == MODE_LIT) begin
              pix = texel_mem[texel_slot()];
              if (mode == MODE_LIT) pix = shade_mem[pix];
              for (int i = 0; i < rep_width; i++) begin
                due_writes.push_back(out_word_t'{dest_address: row_dest + AddrW'(i),
                                                 pixel_value: pix,
                                                 last_of_run: (i == rep_width - 1)});
              end
            end else if (mode == MODE_SHADE_BG) begin
              due_writes.push_back(out_word_t'{dest_address: row_dest,
                                               pixel_value: shade_mem[w.background_pixel],
                                               last_of_run: 1'b1});
            end
            tex_coord = tex_coord + coord_step;
            row_dest  = row_dest + row_pitch;
            rows_left = rows_left - 1'b1;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_write(out_word_t got);
      out_word_t want;
      if (due_writes.size() == 0) begin
        $display("%0t: unexpected write, expected none, got addr %05h pixel %02h last %0b",
                 $time, got.dest_address, got.pixel_value, got.last_of_run);
        mismatches++;
        return;
      end
      want = due_writes.pop_front();
      if (got.dest_address !== want.dest_address) begin
        $display("%0t: dest_address expected %05h got %05h",
                 $time, want.dest_address, got.dest_address);
        mismatches++;
      end
      if (got.pixel_value !== want.pixel_value) begin
        $display("%0t: pixel_value expected %02h got %02h (addr %05h)",
                 $time, want.pixel_value, got.pixel_value, want.dest_address);
        mismatches++;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $display("%0t: last_of_run expected %0b got %0b (addr %05h)",
                 $time, want.last_of_run, got.last_of_run, want.dest_address);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_word_t          in_word = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_word_t         out_word;
  logic              cfg_we = 1'b0;
  logic [PitchW-1:0] cfg_wdata = PitchReset;

  column_model model;
  bit          no_gaps = 1'b0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  int          sent_items = 0;
  int          quiet_cycles = 0;

  scaled_column_drawer_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) model.check_write(out_word);
  end

  // receiver: random stalls, plus one long hold when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !no_gaps && ($urandom_range(0, 99) < 16);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= IdleLimit) begin
      $display("%0t: no word moved for %0d cycles", $time, IdleLimit);
      $display("status: fail");
      $finish;
    end
  end

  function automatic in_word_t random_word(cmd_e cmd);
    logic [159:0] r;
    in_word_t     w;
    r = {$urandom, $urandom, $urandom, $urandom, $urandom};
    w = r[$bits(in_word_t)-1:0];
    w.command = cmd;
    return w;
  endfunction

  function automatic in_word_t load_word(cmd_e cmd, logic [11:0] idx, logic [7:0] data);
    in_word_t w;
    w = random_word(cmd);
    w.table_index = idx;
    w.table_data  = data;
    return w;
  endfunction

  function automatic in_word_t start_word(logic [31:0] frac, logic [31:0] stp,
                                          logic [11:0] ofs, logic [19:0] dst,
                                          logic [9:0] len, logic [3:0] wid, mode_e md);
    in_word_t w;
    w = random_word(CMD_START);
    w.frac_start    = frac;
    w.step          = stp;
    w.source_offset = ofs;
    w.dest_start    = dst;
    w.column_length = len;
    w.column_width  = wid;
    w.draw_mode     = md;
    return w;
  endfunction

  task automatic send_word(in_word_t w);
    if (!no_gaps) begin
      while ($urandom_range(0, 99) < 16) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    model.take_word(w);
    sent_items++;
  endtask

  // loads any texel or shade entry the row will read that was never written
  task automatic send_row(logic [7:0] bg);
    logic [TexelAw-1:0] slot;
    logic [7:0]         tv;
    if (model.rows_left != 0) begin
      if (model.mode == MODE_PLAIN || model.mode == MODE_LIT) begin
        slot = model.texel_slot();
        if (!model.texel_known[slot])
          send_word(load_word(CMD_LOAD_TEXEL, 12'(slot), 8'($urandom)));
        tv = model.texel_mem[slot];
        if (model.mode == MODE_LIT && !model.shade_known[tv])
          send_word(load_word(CMD_LOAD_SHADE, {4'($urandom), tv}, 8'($urandom)));
      end else if (model.mode == MODE_SHADE_BG && !model.shade_known[bg]) begin
        send_word(load_word(CMD_LOAD_SHADE, {4'($urandom), bg}, 8'($urandom)));
      end
    end
    begin
      in_word_t w;
      w = random_word(CMD_ROW);
      w.background_pixel = bg;
      send_word(w);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (model.due_writes.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_pitch(logic [PitchW-1:0] pitch);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= pitch;
    @(posedge clk);
    cfg_we <= 1'b0;
    model.row_pitch = pitch;
  endtask

  task automatic run_directed();
    send_row(8'h00);  // row word with no column started
    send_word(load_word(CMD_LOAD_TEXEL, 12'hFFF, 8'hFF));
    send_word(load_word(CMD_LOAD_TEXEL, 12'h000, 8'h00));
    send_word(load_word(CMD_LOAD_SHADE, 12'hFFF, 8'hA5));
    send_word(load_word(CMD_LOAD_SHADE, 12'h000, 8'hFF));
    // width zero taken as one, extra row after the column ends
    send_word(start_word(32'h0, 32'h0001_0000, 12'h000, 20'h00000, 10'd2, 4'd0, MODE_PLAIN));
    repeat (3) send_row(8'($urandom));
    // coordinate and address wrap, width saturated
    send_word(start_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF, 20'hFFFFF, 10'd2, 4'd15,
                         MODE_LIT));
    repeat (2) send_row(8'($urandom));
    send_word(start_word(32'h0, 32'h0, 12'h0, 20'hFFFFC, 10'd1, 4'd8, MODE_SHADE_BG));
    send_row(8'hFF);
    send_row(8'h00);
    // mode without meaning: rows consumed, nothing written
    send_word(start_word(32'h1234_5678, 32'h0002_8000, 12'h055, 20'h0AAAA, 10'd3, 4'd4,
                         MODE_NONE));
    repeat (3) send_row(8'($urandom));
    send_word(start_word(32'h0, 32'h0001_0000, 12'h0, 20'h0, 10'd0, 4'd3, MODE_PLAIN));
    send_row(8'($urandom));
    send_word(start_word(32'h0, 32'h0, 12'hAAA, 20'hFFFFE, 10'h3FF, 4'd8, MODE_PLAIN));
    repeat (2) send_row(8'($urandom));
  endtask

  task automatic run_columns(int n_items);
    int          target;
    int          n_rows;
    logic [9:0]  len;
    logic [3:0]  wid;
    logic [31:0] stp;
    mode_e       md;
    cmd_e        cmd;
    target = sent_items + n_items;
    while (sent_items < target) begin
      if ($urandom_range(0, 99) < 15) begin
        cmd = cmd_e'($urandom_range(0, 3));
        if (cmd == CMD_ROW) send_row(8'($urandom));
        else send_word(random_word(cmd));
      end else begin
        case ($urandom_range(0, 9))
          0:       len = 10'd0;
          1:       len = 10'($urandom);
          default: len = 10'($urandom_range(1, 12));
        endcase
        wid = ($urandom_range(0, 9) < 3) ? 4'($urandom) : 4'($urandom_range(1, MaxWidth));
        md  = ($urandom_range(0, 9) == 0) ? MODE_NONE : mode_e'($urandom_range(0, 2));
        stp = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 32'h3FFFF)) : $urandom;
        send_word(start_word($urandom, stp, 12'($urandom), 20'($urandom), len, wid, md));
        n_rows = (len > 14) ? 14 : int'(len);
        n_rows += $urandom_range(0, 2);
        repeat (n_rows) send_row(8'($urandom));
      end
    end
  endtask

  initial begin
    model = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();

    write_pitch(PitchW'(1));
    run_columns(PhaseItems);

    // long output hold while words keep coming, to back up the row queue
    write_pitch(PitchW'(4095));
    hold_req = 1'b1;
    run_columns(PhaseItems);

    write_pitch(PitchW'($urandom_range(2, 4094)));
    no_gaps = 1'b1;
    run_columns(PhaseItems);
    no_gaps = 1'b0;

    write_pitch(PitchReset);
    run_columns(PhaseItems);

    wait_idle();
    if (model.mismatches == 0 && model.due_writes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/scd_pkg.sv
src/scd_front.sv
src/scd_queue.sv
src/scd_back.sv
src/scaled_column_drawer_top.sv
tb/sv/scaled_column_drawer_top_tb.sv
